[rtl/ljvs_pkg.sv]
`default_nettype none

package ljvs_pkg;

    localparam int QW = 48;

    localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

    // Item modes.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_TIME_STEP = 2'd0;
    localparam logic [1:0] REG_REPULSIVE = 2'd1;
    localparam logic [1:0] REG_ATTRACTIVE = 2'd2;
    localparam logic [1:0] REG_INV_MASS = 2'd3;

    typedef struct packed {
        logic              mode;
        logic [1:0]        particle;
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic signed [47:0] pos_z;
    } ljvs_in_t;

    typedef struct packed {
        logic signed [47:0] potential_energy;
        logic [46:0]        kinetic_energy;
        logic signed [47:0] total_energy;
        logic [62:0]        drift_sum;
    } ljvs_out_t;

    typedef struct packed {
        logic               start;
        logic signed [47:0] a;
        logic signed [47:0] b;
    } ljvs_mul_req_t;

    typedef struct packed {
        logic        start;
        logic [47:0] d;
    } ljvs_rcp_req_t;

    typedef struct packed {
        logic               done;
        logic signed [47:0] q;
    } ljvs_rsp_t;

    function automatic logic signed [47:0] sat49(input logic signed [48:0] s);
        logic signed [47:0] r;
        if (s[48] != s[47]) begin
            r = s[48] ? Q_MIN : Q_MAX;
        end else begin
            r = s[47:0];
        end
        return r;
    endfunction

    function automatic logic signed [47:0] add_sat(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
        logic signed [48:0] s;
        s = {a[47], a} + {b[47], b};
        return sat49(s);
    endfunction

    function automatic logic signed [47:0] sub_sat(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
        logic signed [48:0] s;
        s = {a[47], a} - {b[47], b};
        return sat49(s);
    endfunction

    // Halving that truncates toward zero.
    function automatic logic signed [47:0] half_tz(input logic signed [47:0] x);
        logic signed [47:0] s;
        s = x + 48'(x[47]);
        return s >>> 1;
    endfunction

endpackage

`default_nettype wire

[rtl/lennard_jones_verlet_step_core.sv]
`default_nettype none

// Channel    Direction  Handshake          Payload
// s_         in         s_valid/s_ready    ljvs_in_t: mode, particle, pos_x/y/z
// m_         out        m_valid/m_ready    ljvs_out_t: energies and drift sum
// cfg_       in         cfg_wr_en          cfg_index selects, cfg_wdata carries the value
//
// A load item makes six memory writes. A step item runs two force passes over
// every particle pair and updates position and velocity for each of the
// 3*PARTICLES coordinate entries; it also clears the force arrays and forms the
// coefficients. Step time is set by the shared multiplier and the bit-serial
// reciprocal, which skips the division when it saturates. After reset a clearing
// pass writes zero to all 4*2^ceil(log2(3*PARTICLES)) entries of the state
// memory; no transfer is taken then. A finished result waits in the output
// register while the next item is taken; a step only stalls at its end if the
// previous result is still held.
module lennard_jones_verlet_step_core
    import ljvs_pkg::*;
#(
    parameter int PARTICLES = 4
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  ljvs_in_t    s_data,
    output logic        m_valid,
    input  wire         m_ready,
    output ljvs_out_t   m_data,
    input  wire         cfg_wr_en,
    input  wire [1:0]   cfg_index,
    input  wire [40:0]  cfg_wdata
);

    // One state memory holds four arrays, each 3*PARTICLES entries, selected by
    // the top two address bits.
    localparam int PW = $clog2(PARTICLES);
    localparam int IW = $clog2(3 * PARTICLES);
    localparam int AW = IW + 2;
    localparam int DEPTH = 4 << IW;
    localparam logic [IW-1:0] LAST_IDX = IW'(3 * PARTICLES - 1);
    localparam logic [PW-1:0] LAST_P = PW'(PARTICLES - 1);
    localparam logic [PW-1:0] LAST_I = PW'(PARTICLES - 2);

    localparam logic [1:0] ARR_POS  = 2'd0;
    localparam logic [1:0] ARR_VEL  = 2'd1;
    localparam logic [1:0] ARR_OLDF = 2'd2;
    localparam logic [1:0] ARR_NEWF = 2'd3;

    localparam logic [5:0] ST_CLEAR  = 6'd0;
    localparam logic [5:0] ST_IDLE   = 6'd1;
    localparam logic [5:0] ST_LOAD_P = 6'd2;
    localparam logic [5:0] ST_LOAD_V = 6'd3;
    localparam logic [5:0] ST_ZF     = 6'd4;
    localparam logic [5:0] ST_WAIT   = 6'd5;
    localparam logic [5:0] ST_PA_RI  = 6'd6;
    localparam logic [5:0] ST_PA_RJ  = 6'd7;
    localparam logic [5:0] ST_PA_DF  = 6'd8;
    localparam logic [5:0] ST_PA_R2  = 6'd9;
    localparam logic [5:0] ST_PA_I2  = 6'd10;
    localparam logic [5:0] ST_PA_I4  = 6'd11;
    localparam logic [5:0] ST_PA_I6  = 6'd12;
    localparam logic [5:0] ST_PA_I12 = 6'd13;
    localparam logic [5:0] ST_PA_FA  = 6'd14;
    localparam logic [5:0] ST_PA_FB  = 6'd15;
    localparam logic [5:0] ST_PA_FC  = 6'd16;
    localparam logic [5:0] ST_PA_UA  = 6'd17;
    localparam logic [5:0] ST_PA_UB  = 6'd18;
    localparam logic [5:0] ST_PA_FI  = 6'd19;
    localparam logic [5:0] ST_PA_WI  = 6'd20;
    localparam logic [5:0] ST_PA_WJ  = 6'd21;
    localparam logic [5:0] ST_PA_NX  = 6'd22;
    localparam logic [5:0] ST_PC0    = 6'd23;
    localparam logic [5:0] ST_PC1    = 6'd24;
    localparam logic [5:0] ST_PC2    = 6'd25;
    localparam logic [5:0] ST_PU_RV  = 6'd26;
    localparam logic [5:0] ST_PU_MV  = 6'd27;
    localparam logic [5:0] ST_PU_RP  = 6'd28;
    localparam logic [5:0] ST_PU_AP  = 6'd29;
    localparam logic [5:0] ST_PU_MF  = 6'd30;
    localparam logic [5:0] ST_PU_WP  = 6'd31;
    localparam logic [5:0] ST_VC0    = 6'd32;
    localparam logic [5:0] ST_VC1    = 6'd33;
    localparam logic [5:0] ST_VC2    = 6'd34;
    localparam logic [5:0] ST_VU_RO  = 6'd35;
    localparam logic [5:0] ST_VU_RN  = 6'd36;
    localparam logic [5:0] ST_VU_MS  = 6'd37;
    localparam logic [5:0] ST_VU_RV  = 6'd38;
    localparam logic [5:0] ST_VU_WV  = 6'd39;
    localparam logic [5:0] ST_VU_K1  = 6'd40;
    localparam logic [5:0] ST_VU_K2  = 6'd41;
    localparam logic [5:0] ST_FIN    = 6'd42;

    function automatic logic [IW-1:0] idx_of(input logic [PW-1:0] p,
                                             input logic [1:0] cc);
        return IW'({p, 1'b0}) + IW'(p) + IW'(cc);
    endfunction

    // Configuration registers.
    logic [32:0] time_step_reg;
    logic [40:0] rep_reg, att_reg, inv_mass_reg;

    // Sequencer state.
    logic [5:0]    state_reg, state_next;
    logic [5:0]    ret_reg, ret_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [IW-1:0] k_reg, k_next;
    logic [1:0]    c_reg, c_next;
    logic [PW-1:0] i_reg, i_next, j_reg, j_next;
    logic          pass_reg, pass_next;
    logic [PW-1:0] ld_p_reg, ld_p_next;
    logic signed [47:0] ld_x_reg, ld_x_next, ld_y_reg, ld_y_next, ld_z_reg, ld_z_next;

    // Datapath registers.
    logic signed [47:0] pi_reg, pi_next;
    logic signed [47:0] d_reg [3];
    logic signed [47:0] d_next [3];
    logic signed [47:0] r2_reg, r2_next, r2i_reg, r2i_next;
    logic signed [47:0] r6i_reg, r6i_next, r12i_reg, r12i_next;
    logic signed [47:0] fc_reg, fc_next, fd_reg, fd_next, t_reg, t_next;
    logic signed [47:0] pot_reg, pot_next, kin_reg, kin_next;
    logic signed [47:0] pos_coef_reg, pos_coef_next, vel_coef_reg, vel_coef_next;
    logic signed [47:0] mass_reg, mass_next;

    // Energy record and output register.
    logic signed [47:0] first_reg, first_next;
    logic               have_first_reg, have_first_next;
    logic [62:0]        drift_reg, drift_next;
    logic               m_valid_reg, m_valid_next;
    ljvs_out_t          m_data_reg, m_data_next;

    // Memory port.
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [47:0]   mem_wdata, mem_rdata;
    logic signed [47:0] rd_s;

    ljvs_mul_req_t mul_req;
    ljvs_rcp_req_t rcp_req;
    ljvs_rsp_t     mul_rsp, rcp_rsp;

    // Shared combinational terms.
    logic signed [47:0] dt_s, im_s, c12_s, c6_s, cf12_s, cf6_s;
    logic signed [47:0] d_cur, r2_sum, tot_val, first_use, vel_new;
    logic signed [48:0] dev;
    logic [47:0]        dev_mag;
    logic [63:0]        drift_sum;
    logic [1:0]         fsel, c_inc;
    logic               ld_ok;

    assign rd_s   = $signed(mem_rdata);
    assign dt_s   = $signed(48'(time_step_reg));
    assign im_s   = $signed(48'(inv_mass_reg));
    assign c12_s  = $signed(48'(rep_reg));
    assign c6_s   = $signed(48'(att_reg));
    assign cf12_s = $signed((48'(rep_reg) << 3) + (48'(rep_reg) << 2));
    assign cf6_s  = $signed((48'(att_reg) << 2) + (48'(att_reg) << 1));
    assign d_cur  = sub_sat(pi_reg, rd_s);
    assign r2_sum = add_sat(r2_reg, mul_rsp.q);
    assign vel_new = add_sat(rd_s, t_reg);
    assign fsel   = pass_reg ? ARR_NEWF : ARR_OLDF;
    assign c_inc  = c_reg + 2'd1;
    assign ld_ok  = int'(s_data.particle) < PARTICLES;

    // The first step after a load records its own total, so its deviation is zero.
    assign tot_val   = add_sat(pot_reg, kin_reg);
    assign first_use = have_first_reg ? first_reg : tot_val;
    assign dev       = {first_use[47], first_use} - {tot_val[47], tot_val};
    assign dev_mag   = dev[48] ? 48'(-dev) : dev[47:0];
    assign drift_sum = {1'b0, drift_reg} + 64'(dev_mag);

    ljvs_ram #(
        .WIDTH (48),
        .DEPTH (DEPTH)
    ) u_state_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ljvs_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    ljvs_recip u_recip (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rcp_req),
        .rsp     (rcp_rsp)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The sequencer makes at most one read and one write per state and waits for
    // each arithmetic result; a read never targets the entry written in that state.
    always_comb begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        clr_next        = clr_reg;
        k_next          = k_reg;
        c_next          = c_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        pass_next       = pass_reg;
        ld_p_next       = ld_p_reg;
        ld_x_next       = ld_x_reg;
        ld_y_next       = ld_y_reg;
        ld_z_next       = ld_z_reg;
        pi_next         = pi_reg;
        d_next          = d_reg;
        r2_next         = r2_reg;
        r2i_next        = r2i_reg;
        r6i_next        = r6i_reg;
        r12i_next       = r12i_reg;
        fc_next         = fc_reg;
        fd_next         = fd_reg;
        t_next          = t_reg;
        pot_next        = pot_reg;
        kin_next        = kin_reg;
        pos_coef_next   = pos_coef_reg;
        vel_coef_next   = vel_coef_reg;
        mass_next       = mass_reg;
        first_next      = first_reg;
        have_first_next = have_first_reg;
        drift_next      = drift_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        mul_req         = '0;
        rcp_req         = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == {AW{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.mode == MODE_LOAD) begin
                        if (ld_ok) begin
                            ld_p_next       = PW'(s_data.particle);
                            ld_x_next       = s_data.pos_x;
                            ld_y_next       = s_data.pos_y;
                            ld_z_next       = s_data.pos_z;
                            c_next          = '0;
                            first_next      = '0;
                            have_first_next = 1'b0;
                            drift_next      = '0;
                            state_next      = ST_LOAD_P;
                        end
                    end else begin
                        pass_next  = 1'b0;
                        k_next     = '0;
                        state_next = ST_ZF;
                    end
                end
            end
            ST_LOAD_P: begin
                mem_we    = 1'b1;
                mem_waddr = {ARR_POS, idx_of(ld_p_reg, c_reg)};
                case (c_reg)
                    2'd0: mem_wdata = ld_x_reg;
                    2'd1: mem_wdata = ld_y_reg;
                    default: mem_wdata = ld_z_reg;
                endcase
                if (c_reg == 2'd2) begin
                    c_next     = '0;
                    state_next = ST_LOAD_V;
                end else begin
                    c_next = c_inc;
                end
            end
            ST_LOAD_V: begin
                mem_we    = 1'b1;
                mem_waddr = {ARR_VEL, idx_of(ld_p_reg, c_reg)};
                if (c_reg == 2'd2) begin
                    c_next     = '0;
                    state_next = ST_IDLE;
                end else begin
                    c_next = c_inc;
                end
            end
            ST_ZF: begin
                mem_we    = 1'b1;
                mem_waddr = {fsel, k_reg};
                if (k_reg == LAST_IDX) begin
                    k_next     = '0;
                    i_next     = '0;
                    j_next     = PW'(1);
                    c_next     = '0;
                    pot_next   = '0;
                    r2_next    = '0;
                    state_next = ST_PA_RI;
                end else begin
                    k_next = k_reg + IW'(1);
                end
            end
            ST_WAIT: begin
                if (mul_rsp.done || rcp_rsp.done) begin
                    state_next = ret_reg;
                end
            end
            ST_PA_RI: begin
                mem_re     = 1'b1;
                mem_raddr  = {ARR_POS, idx_of(i_reg, c_reg)};
                state_next = ST_PA_RJ;
            end
            ST_PA_RJ: begin
                pi_next    = rd_s;
                mem_re     = 1'b1;
                mem_raddr  = {ARR_POS, idx_of(j_reg, c_reg)};
                state_next = ST_PA_DF;
            end
            ST_PA_DF: begin
                d_next[c_reg] = d_cur;
                mul_req    = '{start: 1'b1, a: d_cur, b: d_cur};
                ret_next   = ST_PA_R2;
                state_next = ST_WAIT;
            end
            ST_PA_R2: begin
                r2_next = r2_sum;
                if (c_reg == 2'd2) begin
                    c_next     = '0;
                    rcp_req    = '{start: 1'b1, d: r2_sum};
                    ret_next   = ST_PA_I2;
                    state_next = ST_WAIT;
                end else begin
                    c_next     = c_inc;
                    state_next = ST_PA_RI;
                end
            end
            ST_PA_I2: begin
                r2i_next   = rcp_rsp.q;
                mul_req    = '{start: 1'b1, a: rcp_rsp.q, b: rcp_rsp.q};
                ret_next   = ST_PA_I4;
                state_next = ST_WAIT;
            end
            ST_PA_I4: begin
                mul_req    = '{start: 1'b1, a: mul_rsp.q, b: r2i_reg};
                ret_next   = ST_PA_I6;
                state_next = ST_WAIT;
            end
            ST_PA_I6: begin
                r6i_next   = mul_rsp.q;
                mul_req    = '{start: 1'b1, a: mul_rsp.q, b: mul_rsp.q};
                ret_next   = ST_PA_I12;
                state_next = ST_WAIT;
            end
            ST_PA_I12: begin
                r12i_next  = mul_rsp.q;
                mul_req    = '{start: 1'b1, a: cf12_s, b: mul_rsp.q};
                ret_next   = ST_PA_FA;
                state_next = ST_WAIT;
            end
            ST_PA_FA: begin
                t_next     = mul_rsp.q;
                mul_req    = '{start: 1'b1, a: cf6_s, b: r6i_reg};
                ret_next   = ST_PA_FB;
                state_next = ST_WAIT;
            end
            ST_PA_FB: begin
                mul_req    = '{start: 1'b1, a: sub_sat(t_reg, mul_rsp.q), b: r2i_reg};
                ret_next   = ST_PA_FC;
                state_next = ST_WAIT;
            end
            ST_PA_FC: begin
                fc_next    = mul_rsp.q;
                mul_req    = '{start: 1'b1, a: c12_s, b: r12i_reg};
                ret_next   = ST_PA_UA;
                state_next = ST_WAIT;
            end
            ST_PA_UA: begin
                t_next     = mul_rsp.q;
                mul_req    = '{start: 1'b1, a: c6_s, b: r6i_reg};
                ret_next   = ST_PA_UB;
                state_next = ST_WAIT;
            end
            ST_PA_UB: begin
                pot_next   = add_sat(pot_reg, sub_sat(t_reg, mul_rsp.q));
                c_next     = '0;
                mul_req    = '{start: 1'b1, a: fc_reg, b: d_reg[0]};
                ret_next   = ST_PA_FI;
                state_next = ST_WAIT;
            end
            ST_PA_FI: begin
                fd_next    = mul_rsp.q;
                mem_re     = 1'b1;
                mem_raddr  = {fsel, idx_of(i_reg, c_reg)};
                state_next = ST_PA_WI;
            end
            ST_PA_WI: begin
                mem_we     = 1'b1;
                mem_waddr  = {fsel, idx_of(i_reg, c_reg)};
                mem_wdata  = add_sat(rd_s, fd_reg);
                mem_re     = 1'b1;
                mem_raddr  = {fsel, idx_of(j_reg, c_reg)};
                state_next = ST_PA_WJ;
            end
            ST_PA_WJ: begin
                mem_we    = 1'b1;
                mem_waddr = {fsel, idx_of(j_reg, c_reg)};
                mem_wdata = sub_sat(rd_s, fd_reg);
                if (c_reg == 2'd2) begin
                    state_next = ST_PA_NX;
                end else begin
                    c_next     = c_inc;
                    mul_req    = '{start: 1'b1, a: fc_reg, b: d_reg[c_inc]};
                    ret_next   = ST_PA_FI;
                    state_next = ST_WAIT;
                end
            end
            ST_PA_NX: begin
                r2_next    = '0;
                c_next     = '0;
                state_next = ST_PA_RI;
                if (j_reg == LAST_P) begin
                    if (i_reg == LAST_I) begin
                        state_next = pass_reg ? ST_VC0 : ST_PC0;
                    end else begin
                        i_next = i_reg + PW'(1);
                        j_next = i_reg + PW'(2);
                    end
                end else begin
                    j_next = j_reg + PW'(1);
                end
            end
            ST_PC0: begin
                mul_req    = '{start: 1'b1, a: dt_s, b: dt_s};
                ret_next   = ST_PC1;
                state_next = ST_WAIT;
            end
            ST_PC1: begin
                mul_req    = '{start: 1'b1, a: half_tz(mul_rsp.q), b: im_s};
                ret_next   = ST_PC2;
                state_next = ST_WAIT;
            end
            ST_PC2: begin
                pos_coef_next = mul_rsp.q;
                k_next        = '0;
                state_next    = ST_PU_RV;
            end
            ST_PU_RV: begin
                mem_re     = 1'b1;
                mem_raddr  = {ARR_VEL, k_reg};
                state_next = ST_PU_MV;
            end
            ST_PU_MV: begin
                mul_req    = '{start: 1'b1, a: dt_s, b: rd_s};
                ret_next   = ST_PU_RP;
                state_next = ST_WAIT;
            end
            ST_PU_RP: begin
                t_next     = mul_rsp.q;
                mem_re     = 1'b1;
                mem_raddr  = {ARR_POS, k_reg};
                state_next = ST_PU_AP;
            end
            ST_PU_AP: begin
                t_next     = add_sat(rd_s, t_reg);
                mem_re     = 1'b1;
                mem_raddr  = {ARR_OLDF, k_reg};
                state_next = ST_PU_MF;
            end
            ST_PU_MF: begin
                mul_req    = '{start: 1'b1, a: pos_coef_reg, b: rd_s};
                ret_next   = ST_PU_WP;
                state_next = ST_WAIT;
            end
            ST_PU_WP: begin
                mem_we    = 1'b1;
                mem_waddr = {ARR_POS, k_reg};
                mem_wdata = add_sat(t_reg, mul_rsp.q);
                if (k_reg == LAST_IDX) begin
                    k_next     = '0;
                    pass_next  = 1'b1;
                    state_next = ST_ZF;
                end else begin
                    k_next     = k_reg + IW'(1);
                    state_next = ST_PU_RV;
                end
            end
            ST_VC0: begin
                mul_req    = '{start: 1'b1, a: dt_s, b: im_s};
                ret_next   = ST_VC1;
                state_next = ST_WAIT;
            end
            ST_VC1: begin
                vel_coef_next = mul_rsp.q;
                rcp_req       = '{start: 1'b1, d: 48'(inv_mass_reg)};
                ret_next      = ST_VC2;
                state_next    = ST_WAIT;
            end
            ST_VC2: begin
                mass_next  = rcp_rsp.q;
                k_next     = '0;
                kin_next   = '0;
                state_next = ST_VU_RO;
            end
            ST_VU_RO: begin
                mem_re     = 1'b1;
                mem_raddr  = {ARR_OLDF, k_reg};
                state_next = ST_VU_RN;
            end
            ST_VU_RN: begin
                t_next     = rd_s;
                mem_re     = 1'b1;
                mem_raddr  = {ARR_NEWF, k_reg};
                state_next = ST_VU_MS;
            end
            ST_VU_MS: begin
                mul_req    = '{start: 1'b1, a: vel_coef_reg, b: add_sat(t_reg, rd_s)};
                ret_next   = ST_VU_RV;
                state_next = ST_WAIT;
            end
            ST_VU_RV: begin
                t_next     = half_tz(mul_rsp.q);
                mem_re     = 1'b1;
                mem_raddr  = {ARR_VEL, k_reg};
                state_next = ST_VU_WV;
            end
            ST_VU_WV: begin
                mem_we     = 1'b1;
                mem_waddr  = {ARR_VEL, k_reg};
                mem_wdata  = vel_new;
                mul_req    = '{start: 1'b1, a: vel_new, b: vel_new};
                ret_next   = ST_VU_K1;
                state_next = ST_WAIT;
            end
            ST_VU_K1: begin
                mul_req    = '{start: 1'b1, a: mul_rsp.q, b: mass_reg};
                ret_next   = ST_VU_K2;
                state_next = ST_WAIT;
            end
            ST_VU_K2: begin
                kin_next = add_sat(kin_reg, half_tz(mul_rsp.q));
                if (k_reg == LAST_IDX) begin
                    state_next = ST_FIN;
                end else begin
                    k_next     = k_reg + IW'(1);
                    state_next = ST_VU_RO;
                end
            end
            ST_FIN: begin
                // Hold here until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    first_next      = first_use;
                    have_first_next = 1'b1;
                    drift_next      = drift_sum[63] ? {63{1'b1}} : drift_sum[62:0];
                    m_valid_next    = 1'b1;
                    m_data_next.potential_energy = pot_reg;
                    m_data_next.kinetic_energy   = kin_reg[46:0];
                    m_data_next.total_energy     = tot_val;
                    m_data_next.drift_sum        = drift_sum[63] ? {63{1'b1}}
                                                                 : drift_sum[62:0];
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            ret_reg        <= ST_IDLE;
            clr_reg        <= '0;
            m_valid_reg    <= 1'b0;
            first_reg      <= '0;
            have_first_reg <= 1'b0;
            drift_reg      <= '0;
            time_step_reg  <= 33'd21474836;
            rep_reg        <= 41'd17179869184;
            att_reg        <= 41'd17179869184;
            inv_mass_reg   <= 41'd4294967296;
        end else begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            clr_reg        <= clr_next;
            m_valid_reg    <= m_valid_next;
            first_reg      <= first_next;
            have_first_reg <= have_first_next;
            drift_reg      <= drift_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_TIME_STEP:  time_step_reg <= cfg_wdata[32:0];
                    REG_REPULSIVE:  rep_reg       <= cfg_wdata;
                    REG_ATTRACTIVE: att_reg       <= cfg_wdata;
                    REG_INV_MASS:   inv_mass_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        c_reg        <= c_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        pass_reg     <= pass_next;
        ld_p_reg     <= ld_p_next;
        ld_x_reg     <= ld_x_next;
        ld_y_reg     <= ld_y_next;
        ld_z_reg     <= ld_z_next;
        pi_reg       <= pi_next;
        d_reg        <= d_next;
        r2_reg       <= r2_next;
        r2i_reg      <= r2i_next;
        r6i_reg      <= r6i_next;
        r12i_reg     <= r12i_next;
        fc_reg       <= fc_next;
        fd_reg       <= fd_next;
        t_reg        <= t_next;
        pot_reg      <= pot_next;
        kin_reg      <= kin_next;
        pos_coef_reg <= pos_coef_next;
        vel_coef_reg <= vel_coef_next;
        mass_reg     <= mass_next;
        m_data_reg   <= m_data_next;
    end

    // A new result only appears from the final state of a step.
    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside the final step state");

    // The sequencer never reads an entry in the cycle it writes it.
    a_no_same_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write of one memory entry in the same cycle");

    // Only one arithmetic unit finishes at a time.
    a_one_unit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_rsp.done && rcp_rsp.done))
        else $error("multiplier and reciprocal finished together");

    // A held result stays unchanged until its transfer.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(m_data_reg))
        else $error("held result changed before its transfer");

endmodule

`default_nettype wire

[rtl/ljvs_ram.sv]
`default_nettype none

module ljvs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire                      re,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/ljvs_mul.sv]
`default_nettype none

// Saturating Q16.32 multiply built from four 24x24 partial products.
module ljvs_mul
    import ljvs_pkg::*;
(
    input  wire            aclk,
    input  wire            aresetn,
    input  ljvs_mul_req_t  req,
    output ljvs_rsp_t      rsp
);

    logic [47:0]        am_reg, bm_reg;
    logic               neg_reg;
    logic [95:0]        acc_reg;
    logic [2:0]         step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [47:0] q_reg;

    logic [23:0] pa, pb;
    logic [47:0] part;
    logic [95:0] part_sh;
    logic        big;
    logic [47:0] mag;

    always_comb begin
        pa = am_reg[23:0];
        pb = bm_reg[23:0];
        part_sh = '0;
        case (step_reg)
            3'd0: begin pa = am_reg[23:0];  pb = bm_reg[23:0];  end
            3'd1: begin pa = am_reg[23:0];  pb = bm_reg[47:24]; end
            3'd2: begin pa = am_reg[47:24]; pb = bm_reg[23:0];  end
            default: begin pa = am_reg[47:24]; pb = bm_reg[47:24]; end
        endcase
        part = 48'(pa) * 48'(pb);
        case (step_reg)
            3'd0: part_sh = 96'(part);
            3'd1, 3'd2: part_sh = 96'(part) << 24;
            default: part_sh = 96'(part) << 48;
        endcase
    end

    assign big = |acc_reg[95:79];
    assign mag = {1'b0, acc_reg[78:32]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            am_reg  <= req.a[47] ? (~req.a + 48'd1) : req.a;
            bm_reg  <= req.b[47] ? (~req.b + 48'd1) : req.b;
            neg_reg <= req.a[47] ^ req.b[47];
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (step_reg == 3'd4) begin
                if (neg_reg) begin
                    q_reg <= big ? Q_MIN : (~mag + 48'd1);
                end else begin
                    q_reg <= big ? Q_MAX : mag;
                end
            end else begin
                acc_reg <= acc_reg + part_sh;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

endmodule

`default_nettype wire

[rtl/ljvs_recip.sv]
`default_nettype none

// floor(2^64 / d) saturated to the largest Q16.32 value, one quotient bit per cycle.
module ljvs_recip
    import ljvs_pkg::*;
(
    input  wire            aclk,
    input  wire            aresetn,
    input  ljvs_rcp_req_t  req,
    output ljvs_rsp_t      rsp
);

    localparam logic [47:0] SAT_LIMIT = 48'h2_0000;

    logic [47:0]        d_reg;
    logic [48:0]        rem_reg;
    logic [45:0]        q_reg;
    logic [5:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [47:0] out_reg;

    logic [48:0] rem2;
    logic        ge;

    assign rem2 = {rem_reg[47:0], 1'b0};
    assign ge   = rem2 >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                if (req.d <= SAT_LIMIT) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= 6'd47;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            d_reg   <= req.d;
            rem_reg <= 49'(SAT_LIMIT);
            q_reg   <= '0;
            out_reg <= Q_MAX;
        end else if (busy_reg) begin
            rem_reg <= ge ? (rem2 - {1'b0, d_reg}) : rem2;
            q_reg   <= {q_reg[44:0], ge};
            if (cnt_reg == 6'd1) begin
                out_reg <= {1'b0, q_reg, ge};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = out_reg;

endmodule

`default_nettype wire

[sim/lennard_jones_verlet_step_core_tb.sv]
`default_nettype none

module lennard_jones_verlet_step_core_tb;
    import ljvs_pkg::*;

    localparam int NPART = 4;
    localparam longint QHI = 64'sd140737488355327;
    localparam longint QLO = -64'sd140737488355328;
    localparam bit [63:0] DRIFT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint ONE = 64'sd4294967296;
    // Longest quiet stretch that a correct run can show: one full step,
    // the long receiver hold-off and slack.
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int HOLD_CYCLES = 4000;

    // Saturating fixed-point helpers used by the energy predictor.
    function automatic longint clip(input longint v);
        if (v > QHI) begin
            return QHI;
        end
        if (v < QLO) begin
            return QLO;
        end
        return v;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        bit         neg;
        bit [63:0]  ma;
        bit [63:0]  mb;
        bit [127:0] p;
        bit [63:0]  m;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = {64'd0, ma} * {64'd0, mb};
        m = (p[127:96] != 0) ? '1 : p[95:32];
        if (neg) begin
            if (m >= 64'd1 << 47) begin
                return QLO;
            end
            return -longint'(m);
        end
        if (m > QHI) begin
            return QHI;
        end
        return longint'(m);
    endfunction

    function automatic longint fx_recip(input bit [63:0] d);
        bit [64:0] q;
        if (d <= 1) begin
            return QHI;
        end
        q = {1'b1, 64'd0} / {1'b0, d};
        if (q > QHI) begin
            return QHI;
        end
        return longint'(q);
    endfunction

    // The scoreboard carries its own copy of the particle state and registers.
    class energy_scoreboard;
        bit [63:0] dt_reg, c12_reg, c6_reg, inv_mass_reg;
        longint    pos[NPART][3];
        longint    vel[NPART][3];
        longint    f_old[NPART][3];
        longint    f_new[NPART][3];
        longint    first_total;
        bit        have_first;
        bit [63:0] drift;
        ljvs_out_t pending_energy[$];
        int        errors;

        function void clear_state();
            dt_reg = 64'd21474836;
            c12_reg = 64'd17179869184;
            c6_reg = 64'd17179869184;
            inv_mass_reg = 64'd4294967296;
            foreach (pos[i, c]) begin
                pos[i][c] = 0;
                vel[i][c] = 0;
                f_old[i][c] = 0;
                f_new[i][c] = 0;
            end
            first_total = 0;
            have_first = 0;
            drift = 0;
            errors = 0;
        endfunction

        function void write_reg(input logic [1:0] idx, input bit [40:0] val);
            case (idx)
                REG_TIME_STEP: dt_reg = {31'd0, val[32:0]};
                REG_REPULSIVE: c12_reg = {23'd0, val};
                REG_ATTRACTIVE: c6_reg = {23'd0, val};
                REG_INV_MASS: inv_mass_reg = {23'd0, val};
                default: ;
            endcase
        endfunction

        // One pass over all pairs: forces into f, summed pair energy returned.
        function longint pair_forces(output longint f[NPART][3]);
            longint k12, k6, u, d[3], r2, r2i, r6i, r12i, fc, fd;
            k12 = longint'(c12_reg) * 12;
            k6 = longint'(c6_reg) * 6;
            u = 0;
            foreach (f[i, c]) begin
                f[i][c] = 0;
            end
            for (int i = 0; i < NPART; i++) begin
                for (int j = i + 1; j < NPART; j++) begin
                    r2 = 0;
                    for (int c = 0; c < 3; c++) begin
                        d[c] = clip(pos[i][c] - pos[j][c]);
                        r2 = clip(r2 + fx_mul(d[c], d[c]));
                    end
                    r2i = fx_recip(r2);
                    r6i = fx_mul(fx_mul(r2i, r2i), r2i);
                    r12i = fx_mul(r6i, r6i);
                    fc = fx_mul(clip(fx_mul(k12, r12i) - fx_mul(k6, r6i)), r2i);
                    for (int c = 0; c < 3; c++) begin
                        fd = fx_mul(fc, d[c]);
                        f[i][c] = clip(f[i][c] + fd);
                        f[j][c] = clip(f[j][c] - fd);
                    end
                    u = clip(u + clip(fx_mul(longint'(c12_reg), r12i)
                                      - fx_mul(longint'(c6_reg), r6i)));
                end
            end
            return u;
        endfunction

        // Called for every accepted input transfer.
        function void note_input(input ljvs_in_t it);
            longint    dt, im, pos_k, vel_k, mass, pot, kin, tot, dev;
            ljvs_out_t e;
            dt = longint'(dt_reg);
            im = longint'(inv_mass_reg);
            if (it.mode == MODE_LOAD) begin
                pos[it.particle][0] = longint'(it.pos_x);
                pos[it.particle][1] = longint'(it.pos_y);
                pos[it.particle][2] = longint'(it.pos_z);
                for (int c = 0; c < 3; c++) begin
                    vel[it.particle][c] = 0;
                end
                first_total = 0;
                have_first = 0;
                drift = 0;
                return;
            end
            pot = pair_forces(f_old);
            pos_k = fx_mul(fx_mul(dt, dt) / 2, im);
            foreach (pos[i, c]) begin
                pos[i][c] = clip(clip(pos[i][c] + fx_mul(dt, vel[i][c]))
                                 + fx_mul(pos_k, f_old[i][c]));
            end
            pot = pair_forces(f_new);
            vel_k = fx_mul(dt, im);
            foreach (vel[i, c]) begin
                vel[i][c] = clip(vel[i][c]
                                 + fx_mul(vel_k, clip(f_old[i][c] + f_new[i][c])) / 2);
            end
            mass = fx_recip(inv_mass_reg);
            kin = 0;
            foreach (vel[i, c]) begin
                kin = clip(kin + fx_mul(fx_mul(vel[i][c], vel[i][c]), mass) / 2);
            end
            tot = clip(pot + kin);
            if (!have_first) begin
                first_total = tot;
                have_first = 1;
            end
            dev = first_total - tot;
            if (dev < 0) begin
                dev = -dev;
            end
            if (dev > DRIFT_MAX - drift) begin
                drift = DRIFT_MAX;
            end else begin
                drift = drift + dev;
            end
            e.potential_energy = pot[47:0];
            e.kinetic_energy = kin[46:0];
            e.total_energy = tot[47:0];
            e.drift_sum = drift[62:0];
            pending_energy.push_back(e);
        endfunction

        // Called for every accepted result transfer.
        function void check_result(input ljvs_out_t got);
            ljvs_out_t e;
            if (pending_energy.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending_energy.pop_front();
            if (got.potential_energy !== e.potential_energy) begin
                $display("%0t: potential_energy expected %h actual %h",
                         $time, e.potential_energy, got.potential_energy);
                errors++;
            end
            if (got.kinetic_energy !== e.kinetic_energy) begin
                $display("%0t: kinetic_energy expected %h actual %h",
                         $time, e.kinetic_energy, got.kinetic_energy);
                errors++;
            end
            if (got.total_energy !== e.total_energy) begin
                $display("%0t: total_energy expected %h actual %h",
                         $time, e.total_energy, got.total_energy);
                errors++;
            end
            if (got.drift_sum !== e.drift_sum) begin
                $display("%0t: drift_sum expected %h actual %h",
                         $time, e.drift_sum, got.drift_sum);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    ljvs_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    ljvs_out_t   m_data;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [40:0] cfg_wdata;

    energy_scoreboard energy_sb;
    int  items_sent;
    bit  quiet;         // when set, neither side idles
    bit  hold_req;      // asks the receiver for one long hold-off
    int  idle_cycles;

    lennard_jones_verlet_step_core #(.PARTICLES(NPART)) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Both transfers are observed at the rising edge, where the scoreboard
    // is updated. Inputs only change at the falling edge, so there is no race.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            energy_sb.note_input(s_data);
        end
        if (aresetn && m_valid && m_ready) begin
            energy_sb.check_result(m_data);
        end
    end

    // The watchdog counts cycles without any transfer or register write.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("lennard_jones_verlet_step_core_tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The receiver stalls in random bursts, and once holds off for a long
    // stretch so that a held result blocks the next step.
    initial begin : receiver
        int burst;
        int hold;
        bit held;
        burst = 0;
        hold = 0;
        held = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !held) begin
                hold = HOLD_CYCLES;
                held = 1;
            end
            if (hold > 0) begin
                hold--;
                m_ready = 1'b0;
            end else if (quiet) begin
                m_ready = 1'b1;
            end else if (burst > 0) begin
                burst--;
                m_ready = 1'b0;
            end else begin
                m_ready = 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    burst = $urandom_range(1, 5);
                end
            end
        end
    end

    // Offers one item and holds it until the transfer happens. A random
    // gap may come first.
    task automatic send_item(input ljvs_in_t it);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_data = it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic load_particle(input logic [1:0] p, input longint x, input longint y,
                                 input longint z);
        ljvs_in_t it;
        it.mode = MODE_LOAD;
        it.particle = p;
        it.pos_x = x[47:0];
        it.pos_y = y[47:0];
        it.pos_z = z[47:0];
        send_item(it);
    endtask

    // A step item carries random position bits, which the block ignores.
    task automatic step_once();
        ljvs_in_t   it;
        logic [159:0] r;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom};
        it = r[$bits(ljvs_in_t)-1:0];
        it.mode = MODE_STEP;
        send_item(it);
    endtask

    task automatic write_reg(input logic [1:0] idx, input bit [40:0] val);
        @(negedge aclk);
        s_valid = 1'b0;
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        energy_sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Registers may only change while the block is idle: every result in,
    // then enough cycles for a trailing load to finish.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (energy_sb.pending_energy.size() != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
    endtask

    function automatic longint rand_full();
        return longint'({$urandom, $urandom}) <<< 16 >>> 16;
    endfunction

    // Coordinate near a lattice point, spacing about 1.2 with some jitter.
    function automatic longint near_site(input int k);
        return longint'(k) * (ONE + ONE / 5) + longint'($urandom_range(0, 1 << 30))
               - (64'sd1 << 29);
    endfunction

    task automatic random_sequence();
        int nsteps;
        if ($urandom_range(0, 9) < 8) begin
            // Well-formed: place all particles on a small cluster, then integrate.
            for (int p = 0; p < NPART; p++) begin
                load_particle(p[1:0], near_site(p & 1), near_site(p >> 1),
                              near_site(int'($urandom_range(0, 1))));
            end
            nsteps = $urandom_range(1, 6);
            repeat (nsteps) step_once();
        end else if ($urandom_range(0, 1) == 0) begin
            load_particle(2'($urandom_range(0, NPART - 1)), rand_full(), rand_full(),
                          rand_full());
        end else begin
            step_once();
        end
    endtask

    task automatic random_config();
        write_reg(REG_TIME_STEP, 41'($urandom_range(1 << 22, 1 << 26)));
        write_reg(REG_REPULSIVE, 41'($urandom_range(1 << 28, 1 << 31)) << 3);
        write_reg(REG_ATTRACTIVE, 41'($urandom_range(1 << 28, 1 << 31)) << 3);
        write_reg(REG_INV_MASS, 41'($urandom_range(1 << 28, 1 << 31)) << 3);
    endtask

    initial begin : stimulus
        energy_sb = new();
        energy_sb.clear_state();
        items_sent = 0;
        quiet = 0;
        hold_req = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_TIME_STEP;
        cfg_wdata = '0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part under the reset register values: a plain step from an
        // all-zero state (coincident particles), field extremes, a coincident
        // pair inside a cluster, and a load that resets the energy record.
        step_once();
        load_particle(2'd0, QHI, QLO, 64'sd0);
        load_particle(2'd1, QLO, QHI, -64'sd1);
        load_particle(2'd2, 64'sd0, 64'sd0, QHI);
        load_particle(2'd3, -64'sd1, 64'sd0, QLO);
        step_once();
        step_once();
        load_particle(2'd0, 64'sd0, 64'sd0, 64'sd0);
        load_particle(2'd1, ONE, 64'sd0, 64'sd0);
        load_particle(2'd2, 64'sd0, ONE, 64'sd0);
        load_particle(2'd3, 64'sd0, ONE, 64'sd0);
        step_once();
        step_once();
        load_particle(2'd3, ONE, ONE, ONE + ONE / 8);
        step_once();
        step_once();
        step_once();
        wait_idle();

        // Each phase sets the registers, then runs random sequences. The
        // second and third phases use the extremes; the long receiver hold-off
        // comes in the first random phase.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                1: begin
                    write_reg(REG_TIME_STEP, 41'd1 << 32);
                    write_reg(REG_REPULSIVE, 41'd1 << 40);
                    write_reg(REG_ATTRACTIVE, 41'd1 << 40);
                    write_reg(REG_INV_MASS, 41'd0);
                end
                2: begin
                    write_reg(REG_TIME_STEP, 41'd0);
                    write_reg(REG_REPULSIVE, 41'd0);
                    write_reg(REG_ATTRACTIVE, 41'd0);
                    write_reg(REG_INV_MASS, 41'd1 << 40);
                end
                3: begin
                    write_reg(REG_TIME_STEP, 41'd21474836);
                    write_reg(REG_REPULSIVE, 41'd17179869184);
                    write_reg(REG_ATTRACTIVE, 41'd17179869184);
                    write_reg(REG_INV_MASS, 41'd4294967296);
                end
                default: if (phase != 0) random_config();
            endcase
            if (phase == 0) begin
                hold_req = 1;
            end
            if (phase == 5) begin
                quiet = 1;
            end
            while (items_sent < 25 + (phase + 1) * 88) begin
                random_sequence();
                if (hold_req && items_sent > 60) begin
                    hold_req = 0;
                end
            end
            wait_idle();
        end

        // Let any stray result show up before the verdict.
        repeat (3000) @(negedge aclk);
        if (energy_sb.errors == 0 && energy_sb.pending_energy.size() == 0) begin
            $display("lennard_jones_verlet_step_core_tb: clean");
        end else begin
            $display("lennard_jones_verlet_step_core_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
